>>> sv/bsas_pkg.sv
// ----------------------------------------------------------------------------
// bsas_pkg
// Shared types and constants for the signed BCD add/subtract/shift unit.
// ----------------------------------------------------------------------------
package bsas_pkg;

  localparam int WORD_W    = 64;  // packed BCD port width, sixteen digits max
  localparam int COUNT_W   = 5;   // significant digit count, 0..16
  localparam int DSUM_W    = 5;   // one digit sum, 0..19

  localparam logic [3:0]        DIGIT_MAX = 4'd9;
  localparam logic [DSUM_W-1:0] DEC_BASE  = 5'd10;
  localparam logic [DSUM_W-1:0] DEC_NINE  = 5'd9;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_DIV = 2'd2,
    KIND_MUL = 2'd3
  } kind_t;

  // control carried alongside the digit data out of the first stage
  typedef struct packed {
    kind_t kind;
    logic  sign_a;
    logic  sign_b_eff;  // sign of B after subtract flips it
    logic  same_sign;   // magnitudes add when set, subtract otherwise
    logic  shift_ovf;   // multiply by ten lost a nonzero top digit
  } ctl_t;

  // status of a resolved result
  typedef struct packed {
    logic sign;
    logic ovf;
  } stat_t;

endpackage

>>> sv/bcd_signed_add_sub_shift.sv
// ----------------------------------------------------------------------------
// bcd_signed_add_sub_shift
// Signed packed-BCD add, subtract, divide by ten and multiply by ten.
// ----------------------------------------------------------------------------
// Fixed-width signed decimal unit on sign-magnitude packed BCD (digit 0 in
// bits 3:0, DIGITS digits used, nibbles above nine read as nine, nibbles past
// the top digit ignored). kind selects add, subtract, divide by ten or
// multiply by ten. Add/subtract run a ten's complement decimal adder; when the
// magnitude does not fit, operand A comes back unchanged with overflow set.
// Multiply by ten overflows the same way when A's top digit is nonzero.
// A zero result is always positive, and digit_count gives the significant
// digits of result_mag (zero for a zero result).
// Timing: three register stages; one item is taken per cycle while op_stall
// is low. Stage 1 cleans digits and forms per-digit sums, stage 2 propagates
// decimal carries (one binary carry chain per adder) and selects the result,
// stage 3 counts digits and holds the output. res_stall holds every stage
// that has a valid item; empty stages still fill, so op_stall rises only once
// the pipe is full.
// ----------------------------------------------------------------------------
module bcd_signed_add_sub_shift #(
  parameter int DIGITS = 16  // 2..16
) (
  input  logic                          clk,
  input  logic                          rst,
  // operation channel
  input  logic                          op_valid,
  output logic                          op_stall,
  input  logic [1:0]                    kind,
  input  logic [bsas_pkg::WORD_W-1:0]   operand_a,
  input  logic                          sign_a,
  input  logic [bsas_pkg::WORD_W-1:0]   operand_b,
  input  logic                          sign_b,
  // result channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [bsas_pkg::WORD_W-1:0]   result_mag,
  output logic                          result_sign,
  output logic [bsas_pkg::COUNT_W-1:0]  digit_count,
  output logic                          overflow
);
  import bsas_pkg::*;

  // stage 1 -> stage 2
  logic                          s1_valid, s1_stall;
  ctl_t                          s1_ctl;
  logic [4*DIGITS-1:0]           s1_a_clean, s1_shift_mag;
  logic [DIGITS-1:0][DSUM_W-1:0] s1_x_sum, s1_x_ab, s1_x_ba;
  logic [DIGITS-1:0]             s1_g_sum, s1_p_sum, s1_g_ab, s1_p_ab, s1_g_ba, s1_p_ba;

  // stage 2 -> stage 3
  logic                          s2_valid, s2_stall;
  logic [4*DIGITS-1:0]           s2_mag;
  stat_t                         s2_stat;

  // digit cleanup, shifts, per-digit sums
  bsas_prep #(.DIGITS(DIGITS)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (op_valid),
    .up_stall  (op_stall),
    .kind      (kind),
    .operand_a (operand_a),
    .sign_a    (sign_a),
    .operand_b (operand_b),
    .sign_b    (sign_b),
    .dn_valid  (s1_valid),
    .dn_stall  (s1_stall),
    .ctl       (s1_ctl),
    .a_clean   (s1_a_clean),
    .shift_mag (s1_shift_mag),
    .x_sum     (s1_x_sum),
    .x_ab      (s1_x_ab),
    .x_ba      (s1_x_ba),
    .g_sum     (s1_g_sum),
    .p_sum     (s1_p_sum),
    .g_ab      (s1_g_ab),
    .p_ab      (s1_p_ab),
    .g_ba      (s1_g_ba),
    .p_ba      (s1_p_ba)
  );

  // carry chains and result select
  bsas_resolve #(.DIGITS(DIGITS)) u_resolve (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s1_valid),
    .up_stall  (s1_stall),
    .ctl       (s1_ctl),
    .a_clean   (s1_a_clean),
    .shift_mag (s1_shift_mag),
    .x_sum     (s1_x_sum),
    .x_ab      (s1_x_ab),
    .x_ba      (s1_x_ba),
    .g_sum     (s1_g_sum),
    .p_sum     (s1_p_sum),
    .g_ab      (s1_g_ab),
    .p_ab      (s1_p_ab),
    .g_ba      (s1_g_ba),
    .p_ba      (s1_p_ba),
    .dn_valid  (s2_valid),
    .dn_stall  (s2_stall),
    .mag       (s2_mag),
    .stat      (s2_stat)
  );

  // digit count, sign cleanup, output register
  bsas_pack #(.DIGITS(DIGITS)) u_pack (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (s2_valid),
    .up_stall    (s2_stall),
    .mag         (s2_mag),
    .stat        (s2_stat),
    .dn_valid    (res_valid),
    .dn_stall    (res_stall),
    .result_mag  (result_mag),
    .result_sign (result_sign),
    .digit_count (digit_count),
    .overflow    (overflow)
  );

endmodule

>>> sv/bsas_prep.sv
// ----------------------------------------------------------------------------
// bsas_prep
// Stage 1: digit cleanup, op decode, decimal shifts, per-digit sums with
// generate/propagate flags for the three decimal adders.
// ----------------------------------------------------------------------------
module bsas_prep #(
  parameter int DIGITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_stall,
  input  logic [1:0]                    kind,
  input  logic [bsas_pkg::WORD_W-1:0]   operand_a,
  input  logic                          sign_a,
  input  logic [bsas_pkg::WORD_W-1:0]   operand_b,
  input  logic                          sign_b,
  output logic                          dn_valid,
  input  logic                          dn_stall,
  output bsas_pkg::ctl_t                ctl,
  output logic [4*DIGITS-1:0]           a_clean,
  output logic [4*DIGITS-1:0]           shift_mag,
  output logic [DIGITS-1:0][bsas_pkg::DSUM_W-1:0] x_sum,
  output logic [DIGITS-1:0][bsas_pkg::DSUM_W-1:0] x_ab,
  output logic [DIGITS-1:0][bsas_pkg::DSUM_W-1:0] x_ba,
  output logic [DIGITS-1:0]             g_sum,
  output logic [DIGITS-1:0]             p_sum,
  output logic [DIGITS-1:0]             g_ab,
  output logic [DIGITS-1:0]             p_ab,
  output logic [DIGITS-1:0]             g_ba,
  output logic [DIGITS-1:0]             p_ba
);
  import bsas_pkg::*;

  logic                            hold;
  logic [4*DIGITS-1:0]             ma, mb;
  kind_t                           kind_in;
  ctl_t                            ctl_next;
  logic [4*DIGITS-1:0]             shift_next;
  logic [DIGITS-1:0][DSUM_W-1:0]   xs_next, xab_next, xba_next;

  assign hold     = dn_valid && dn_stall;
  assign up_stall = hold;
  assign kind_in  = kind_t'(kind);

  // digits above nine read as nine, digits beyond the top are dropped
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      ma[4*i +: 4] = (operand_a[4*i +: 4] > DIGIT_MAX) ? DIGIT_MAX : operand_a[4*i +: 4];
      mb[4*i +: 4] = (operand_b[4*i +: 4] > DIGIT_MAX) ? DIGIT_MAX : operand_b[4*i +: 4];
    end
  end

  always_comb begin
    ctl_next.kind       = kind_in;
    ctl_next.sign_a     = sign_a;
    ctl_next.sign_b_eff = (kind_in == KIND_SUB) ? !sign_b : sign_b;
    ctl_next.same_sign  = (sign_a == ctl_next.sign_b_eff);
    ctl_next.shift_ovf  = (ma[4*(DIGITS-1) +: 4] != 4'd0);
    if (kind_in == KIND_MUL) begin
      shift_next = {ma[4*DIGITS-5:0], 4'd0};
    end else begin
      shift_next = {4'd0, ma[4*DIGITS-1:4]};
    end
  end

  // A+B, A+9c(B), B+9c(A) digit by digit; the +1 goes in as carry later
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      xs_next[i]  = {1'b0, ma[4*i +: 4]} + {1'b0, mb[4*i +: 4]};
      xab_next[i] = {1'b0, ma[4*i +: 4]} + (DEC_NINE - {1'b0, mb[4*i +: 4]});
      xba_next[i] = {1'b0, mb[4*i +: 4]} + (DEC_NINE - {1'b0, ma[4*i +: 4]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!hold) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      ctl       <= ctl_next;
      a_clean   <= ma;
      shift_mag <= shift_next;
      x_sum     <= xs_next;
      x_ab      <= xab_next;
      x_ba      <= xba_next;
      for (int i = 0; i < DIGITS; i++) begin
        g_sum[i] <= (xs_next[i]  >= DEC_BASE);
        p_sum[i] <= (xs_next[i]  == DEC_NINE);
        g_ab[i]  <= (xab_next[i] >= DEC_BASE);
        p_ab[i]  <= (xab_next[i] == DEC_NINE);
        g_ba[i]  <= (xba_next[i] >= DEC_BASE);
        p_ba[i]  <= (xba_next[i] == DEC_NINE);
      end
    end
  end

endmodule

>>> sv/bsas_resolve.sv
// ----------------------------------------------------------------------------
// bsas_resolve
// Stage 2: decimal carry propagation, digit correction and result select.
// ----------------------------------------------------------------------------
module bsas_resolve #(
  parameter int DIGITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_stall,
  input  bsas_pkg::ctl_t                ctl,
  input  logic [4*DIGITS-1:0]           a_clean,
  input  logic [4*DIGITS-1:0]           shift_mag,
  input  logic [DIGITS-1:0][bsas_pkg::DSUM_W-1:0] x_sum,
  input  logic [DIGITS-1:0][bsas_pkg::DSUM_W-1:0] x_ab,
  input  logic [DIGITS-1:0][bsas_pkg::DSUM_W-1:0] x_ba,
  input  logic [DIGITS-1:0]             g_sum,
  input  logic [DIGITS-1:0]             p_sum,
  input  logic [DIGITS-1:0]             g_ab,
  input  logic [DIGITS-1:0]             p_ab,
  input  logic [DIGITS-1:0]             g_ba,
  input  logic [DIGITS-1:0]             p_ba,
  output logic                          dn_valid,
  input  logic                          dn_stall,
  output logic [4*DIGITS-1:0]           mag,
  output bsas_pkg::stat_t               stat
);
  import bsas_pkg::*;

  // carry into every digit plus carry out, via one binary add over g and g|p
  function automatic logic [DIGITS:0] carry_vec(input logic [DIGITS-1:0] g,
                                                input logic [DIGITS-1:0] p,
                                                input logic cin);
    logic [DIGITS-1:0] t;
    logic [DIGITS:0]   s;
    t = g | p;
    s = {1'b0, t} + {1'b0, g} + {{DIGITS{1'b0}}, cin};
    return {s[DIGITS], s[DIGITS-1:0] ^ t ^ g};
  endfunction

  function automatic logic [4*DIGITS-1:0] fix_digits(
      input logic [DIGITS-1:0][DSUM_W-1:0] x, input logic [DIGITS:0] c);
    logic [DSUM_W-1:0]   v;
    logic [4*DIGITS-1:0] r;
    for (int i = 0; i < DIGITS; i++) begin
      v = x[i] + {{(DSUM_W-1){1'b0}}, c[i]};
      if (v >= DEC_BASE) v = v - DEC_BASE;
      r[4*i +: 4] = v[3:0];
    end
    return r;
  endfunction

  logic                hold;
  logic [DIGITS:0]     c_sum, c_ab, c_ba;
  logic [4*DIGITS-1:0] d_sum, d_ab, d_ba;
  logic [4*DIGITS-1:0] mag_next;
  stat_t               stat_next;

  assign hold     = dn_valid && dn_stall;
  assign up_stall = hold;

  always_comb begin
    c_sum = carry_vec(g_sum, p_sum, 1'b0);
    c_ab  = carry_vec(g_ab,  p_ab,  1'b1);
    c_ba  = carry_vec(g_ba,  p_ba,  1'b1);
    d_sum = fix_digits(x_sum, c_sum);
    d_ab  = fix_digits(x_ab,  c_ab);
    d_ba  = fix_digits(x_ba,  c_ba);
  end

  always_comb begin
    mag_next       = a_clean;
    stat_next.sign = ctl.sign_a;
    stat_next.ovf  = 1'b0;
    unique case (ctl.kind)
      KIND_ADD, KIND_SUB: begin
        if (ctl.same_sign) begin
          if (c_sum[DIGITS]) begin
            stat_next.ovf = 1'b1;
          end else begin
            mag_next = d_sum;
          end
        end else if (c_ab[DIGITS]) begin
          // carry out of A-B means |A| >= |B|
          mag_next = d_ab;
        end else begin
          mag_next       = d_ba;
          stat_next.sign = ctl.sign_b_eff;
        end
      end
      KIND_DIV: begin
        mag_next = shift_mag;
      end
      KIND_MUL: begin
        if (ctl.shift_ovf) begin
          stat_next.ovf = 1'b1;
        end else begin
          mag_next = shift_mag;
        end
      end
      default: begin
        mag_next = a_clean;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!hold) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      mag  <= mag_next;
      stat <= stat_next;
    end
  end

endmodule

>>> sv/bsas_pack.sv
// ----------------------------------------------------------------------------
// bsas_pack
// Stage 3: zero test, significant digit count, sign cleanup, output register.
// ----------------------------------------------------------------------------
module bsas_pack #(
  parameter int DIGITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_stall,
  input  logic [4*DIGITS-1:0]           mag,
  input  bsas_pkg::stat_t               stat,
  output logic                          dn_valid,
  input  logic                          dn_stall,
  output logic [bsas_pkg::WORD_W-1:0]   result_mag,
  output logic                          result_sign,
  output logic [bsas_pkg::COUNT_W-1:0]  digit_count,
  output logic                          overflow
);
  import bsas_pkg::*;

  logic               hold;
  logic               is_zero;
  logic [COUNT_W-1:0] count_next;

  assign hold     = dn_valid && dn_stall;
  assign up_stall = hold;
  assign is_zero  = (mag == '0);

  // highest nonzero digit wins
  always_comb begin
    count_next = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (mag[4*i +: 4] != 4'd0) count_next = COUNT_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!hold) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      result_mag  <= WORD_W'(mag);
      result_sign <= stat.sign && !is_zero;
      digit_count <= count_next;
      overflow    <= stat.ovf;
    end
  end

endmodule
